// ===== hdl/lsp_pkg.sv =====
// types, codes and byte-sequencing functions for the lcd spi command/pixel stream
// no dependencies; imported by every module of the block
package lsp_pkg;

    localparam logic [2:0] CMD_SET_WINDOW  = 3'd0;
    localparam logic [2:0] CMD_SET_ORIENT  = 3'd1;
    localparam logic [2:0] CMD_BEGIN_WRITE = 3'd2;
    localparam logic [2:0] CMD_COLOUR_PIX  = 3'd3;
    localparam logic [2:0] CMD_GREY_PIX    = 3'd4;

    localparam logic [7:0] OP_CASET  = 8'h2A;
    localparam logic [7:0] OP_RASET  = 8'h2B;
    localparam logic [7:0] OP_RAMWR  = 8'h2C;
    localparam logic [7:0] OP_MADCTL = 8'h36;
    localparam logic [7:0] ZERO_BYTE = 8'h00;

    localparam logic [7:0] MODE_BYTES [4] = '{8'h00, 8'hA0, 8'hC0, 8'h60};

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  x_start;
        logic [7:0]  y_start;
        logic [7:0]  win_width;
        logic [7:0]  win_height;
        logic [1:0]  orientation;
        logic [14:0] burst_length;
        logic [15:0] pixel_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last;
        logic       burst_done;
    } t_out_item;

    typedef enum logic [1:0] {
        K_WINDOW = 2'd0,
        K_ORIENT = 2'd1,
        K_RAMWR  = 2'd2,
        K_PIXEL  = 2'd3
    } t_kind;

    // window: b0 x start, b1 x end, b2 y start, b3 y end
    // orient: b0 mode byte; pixel: b0 high, b1 low
    typedef struct packed {
        t_kind      kind;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic       done;
    } t_job;

    function automatic t_out_item lsp_byte(input t_job job, input logic [3:0] idx);
        t_out_item o;
        o = '{out_byte: ZERO_BYTE, is_data: 1'b1, last: 1'b0, burst_done: 1'b0};
        unique case (job.kind)
            K_WINDOW: begin
                unique case (idx)
                    4'd0:    begin o.out_byte = OP_CASET; o.is_data = 1'b0; end
                    4'd2:    o.out_byte = job.b0;
                    4'd4:    o.out_byte = job.b1;
                    4'd5:    begin o.out_byte = OP_RASET; o.is_data = 1'b0; end
                    4'd7:    o.out_byte = job.b2;
                    4'd9:    begin o.out_byte = job.b3; o.last = 1'b1; end
                    default: o.out_byte = ZERO_BYTE;
                endcase
            end
            K_ORIENT: begin
                if (idx == 4'd0) begin
                    o.out_byte = OP_MADCTL;
                    o.is_data  = 1'b0;
                end else begin
                    o.out_byte = job.b0;
                    o.last     = 1'b1;
                end
            end
            K_RAMWR: begin
                o.out_byte = OP_RAMWR;
                o.is_data  = 1'b0;
                o.last     = 1'b1;
            end
            K_PIXEL: begin
                if (idx == 4'd0) begin
                    o.out_byte = job.b0;
                end else begin
                    o.out_byte   = job.b1;
                    o.last       = 1'b1;
                    o.burst_done = job.done;
                end
            end
            default: o.out_byte = ZERO_BYTE;
        endcase
        return o;
    endfunction

    function automatic logic [3:0] lsp_len(input t_kind kind);
        logic [3:0] n;
        unique case (kind)
            K_WINDOW: n = 4'd10;
            K_ORIENT: n = 4'd2;
            K_RAMWR:  n = 4'd1;
            K_PIXEL:  n = 4'd2;
            default:  n = 4'd1;
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/lsp_front.sv =====
// front end: accepts requests, tracks the pixel counter and builds jobs for the back end
// depends on lsp_pkg
module lsp_front
    import lsp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_job     o_job,
    output logic     o_job_push
);

    logic [14:0] r_remaining;
    logic [14:0] n_remaining;
    logic [7:0]  grey;
    logic [15:0] colour;

    always_comb begin
        grey        = i_item.pixel_value[7:0];
        colour      = i_item.pixel_value;
        n_remaining = r_remaining;
        o_job       = '{kind: K_RAMWR, b0: '0, b1: '0, b2: '0, b3: '0, done: 1'b0};
        o_job_push  = 1'b0;
        unique case (i_item.cmd)
            CMD_SET_WINDOW: begin
                o_job.kind = K_WINDOW;
                o_job.b0   = i_item.x_start;
                o_job.b1   = 8'(i_item.x_start + i_item.win_width - 8'd1);
                o_job.b2   = i_item.y_start;
                o_job.b3   = 8'(i_item.y_start + i_item.win_height - 8'd1);
                o_job_push = i_accept;
            end
            CMD_SET_ORIENT: begin
                o_job.kind = K_ORIENT;
                o_job.b0   = MODE_BYTES[i_item.orientation];
                o_job_push = i_accept;
            end
            CMD_BEGIN_WRITE: begin
                o_job.kind  = K_RAMWR;
                n_remaining = i_item.burst_length;
                o_job_push  = i_accept;
            end
            CMD_COLOUR_PIX, CMD_GREY_PIX: begin
                // grey level widened to rgb565
                if (i_item.cmd == CMD_GREY_PIX)
                    colour = {grey[7:3], grey[7:2], grey[7:3]};
                o_job.kind = K_PIXEL;
                o_job.b0   = colour[15:8];
                o_job.b1   = colour[7:0];
                if (r_remaining != '0) begin
                    n_remaining = r_remaining - 15'd1;
                    o_job.done  = (r_remaining == 15'd1);
                end
                o_job_push = i_accept;
            end
            default: o_job_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
        end else if (i_accept) begin
            r_remaining <= n_remaining;
        end
    end

endmodule

// ===== hdl/lsp_queue.sv =====
// short job queue between front and back end
// depends on lsp_pkg for the job type
module lsp_queue
    import lsp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr_ptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            if (i_pop)
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            if (i_push && !i_pop)
                r_count <= r_count + CW'(1);
            else if (i_pop && !i_push)
                r_count <= r_count - CW'(1);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop)) else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty) else $error("job queue underflow");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH)) else $error("job queue count out of range");

endmodule

// ===== hdl/lsp_back.sv =====
// back end: steps through each job one byte per cycle into the output register while pop keeps up
// depends on lsp_pkg
module lsp_back
    import lsp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_head,
    input  logic      i_head_empty,
    output logic      o_head_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

    logic       r_busy;
    logic [3:0] r_idx;
    t_job       r_job;
    logic       r_valid;
    t_out_item  r_out;

    t_job       cur_job;
    logic [3:0] cur_idx;
    logic       cur_valid;
    logic       load;
    t_out_item  cur_byte;

    // with no job in hand the queue head is worked on directly, no bubble
    always_comb begin
        cur_job    = r_busy ? r_job : i_head;
        cur_idx    = r_busy ? r_idx : 4'd0;
        cur_valid  = r_busy || !i_head_empty;
        load       = cur_valid && (!r_valid || i_pop);
        cur_byte   = lsp_byte(cur_job, cur_idx);
        o_head_pop = load && !r_busy;
    end

    assign o_empty = !r_valid;
    assign o_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= cur_byte;
            r_job <= cur_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_busy  <= !cur_byte.last;
                r_idx   <= cur_byte.last ? 4'd0 : cur_idx + 4'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    a_idle_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_idx == 4'd0)) else $error("byte index set with no job");
    a_busy_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx != 4'd0 && r_idx < lsp_len(r_job.kind)))
        else $error("byte index beyond job length");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_pop) |=> (r_valid && $stable(r_out)))
        else $error("waiting byte changed");
    a_busy_after_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !r_busy && lsp_len(cur_job.kind) > 4'd1) |=> r_busy)
        else $error("multi-byte job dropped after first byte");

endmodule

// ===== hdl/lcd_spi_command_pixel_stream.sv =====
// top level of the lcd spi command/pixel byte stream generator
// depends on lsp_pkg, lsp_front, lsp_queue, lsp_back
//
//  channel   handshake            payload
//  request   push / full          i_in_item  (t_in_item)
//  byte      pop / empty          o_out_item (t_out_item)
//
// a request is taken while full is low; the back end sends one byte per cycle while pop
// keeps up, so a pixel is 2 bytes, a set-window 10, orientation 2, begin write 1.
// the byte sequencer in lsp_back sets the sustained rate; up to QUEUE_DEPTH jobs buffer.
// full rises only when the job queue is full; invalid codes are taken and dropped.
// synchronous active-low reset clears the pixel counter, queue and output valid flag.
module lcd_spi_command_pixel_stream
    import lsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    input  logic      pop,
    output logic      empty,
    output t_out_item o_out_item
);

    t_job job;
    logic job_push;
    logic q_full;
    t_job head;
    logic head_empty;
    logic head_pop;

    assign full = q_full;

    lsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (push && !q_full),
        .i_item     (i_in_item),
        .o_job      (job),
        .o_job_push (job_push)
    );

    lsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job),
        .o_full  (q_full),
        .i_pop   (head_pop),
        .o_head  (head),
        .o_empty (head_empty)
    );

    lsp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_empty (head_empty),
        .o_head_pop   (head_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_item       (o_out_item)
    );

endmodule
